>>> src/lfsr_memory_pattern_test_defines.svh
// assertion macros for the lfsr memory pattern test
// expects clk and rst_n in the scope of each use
`ifndef LFSR_MEMORY_PATTERN_TEST_DEFINES_SVH
`define LFSR_MEMORY_PATTERN_TEST_DEFINES_SVH

// same-cycle implication
`define LMPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmpt assertion failed");

// next-cycle implication
`define LMPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmpt assertion failed");

`endif

>>> src/lmpt_pkg.sv
// shared types and constants for the lfsr memory pattern test
// no dependencies
package lmpt_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_BITS    = 72;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_READY = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RUNNING = 2'd1,
    ST_PASSED  = 2'd2,
    ST_FAILED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_VERIFY,
    PH_PASSED,
    PH_FAILED
  } phase_t;

  localparam logic [1:0] CFG_WRITE_BASE = 2'd0;
  localparam logic [1:0] CFG_READ_BASE  = 2'd1;
  localparam logic [1:0] CFG_WORD_COUNT = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] read_word;
  } cmd_t;

  typedef struct packed {
    logic [23:0] write_base;
    logic [23:0] read_base;
    logic [23:0] word_count;
  } cfg_t;

  // packed so that access_valid lands in bit 0
  typedef struct packed {
    logic [23:0] fail_address;
    status_t     status;
    logic [15:0] write_word;
    logic [23:0] access_address;
    logic        access_write;
    logic        access_valid;
  } res_t;

  // fibonacci lfsr, taps 16,14,13,11, shifting right
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[15:1]};
  endfunction

endpackage

>>> src/lmpt_front.sv
// front end: accepts input requests, classifies them and queues them
// depends on lmpt_pkg
module lmpt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [15:0]     in_tdata,
  input  logic [1:0]      in_tuser,
  output logic            q_valid,
  input  logic            q_pop,
  output lmpt_pkg::cmd_t  q_cmd
);
  import lmpt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          slot_r [QUEUE_DEPTH];
  cmd_t          cmd_in;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          push;

  assign in_tready = (count_r != (PW+1)'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_cmd     = slot_r[rd_ptr_r];

  // read data only matters for returned reads
  always_comb begin
    cmd_in.kind      = kind_t'(in_tuser);
    cmd_in.read_word = (cmd_in.kind == KIND_DATA) ? in_tdata : 16'd0;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> src/lmpt_back.sv
// back end: test sequencer with lfsr, word counter and result register
// depends on lmpt_pkg
module lmpt_back #(
  parameter int ADDR_WIDTH = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lmpt_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  lmpt_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output lmpt_pkg::res_t  out_res
);
  import lmpt_pkg::*;

  localparam int SW = (ADDR_WIDTH > 24) ? ADDR_WIDTH : 24;
  localparam logic [SW-1:0] ADDR_MASK = {SW{1'b1}} >> (SW - ADDR_WIDTH);

  phase_t      phase_r, phase_nxt;
  logic [23:0] index_r, index_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;
  logic        await_r, await_nxt;
  logic [23:0] fail_r, fail_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;

  logic        take;
  logic [15:0] lfsr_adv;
  logic [23:0] index_inc;
  logic        last_word;
  logic [SW-1:0] wr_sum, rd_sum;
  logic [23:0] wr_addr, rd_addr;

  assign take      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign lfsr_adv  = lfsr_step(lfsr_r);
  assign index_inc = index_r + 24'd1;
  assign last_word = (index_inc >= cfg.word_count);
  assign wr_sum    = SW'(cfg.write_base) + SW'(index_r);
  assign rd_sum    = SW'(cfg.read_base) + SW'(index_r);
  assign wr_addr   = 24'(wr_sum & ADDR_MASK);
  assign rd_addr   = 24'(rd_sum & ADDR_MASK);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    index_nxt = index_r;
    lfsr_nxt  = lfsr_r;
    await_nxt = await_r;
    fail_nxt  = fail_r;
    if (take) begin
      case (q_cmd.kind)
        KIND_START: begin
          lfsr_nxt  = LFSR_SEED;
          index_nxt = '0;
          await_nxt = 1'b0;
          fail_nxt  = '0;
          phase_nxt = (cfg.word_count == '0) ? PH_PASSED : PH_FILL;
        end
        KIND_READY: begin
          if (phase_r == PH_FILL) begin
            lfsr_nxt  = lfsr_adv;
            index_nxt = index_inc;
            if (last_word) begin
              lfsr_nxt  = LFSR_SEED;
              index_nxt = '0;
              phase_nxt = PH_VERIFY;
            end
          end else if (phase_r == PH_VERIFY && !await_r) begin
            await_nxt = 1'b1;
          end
        end
        KIND_DATA: begin
          if (phase_r == PH_VERIFY && await_r) begin
            lfsr_nxt  = lfsr_adv;
            await_nxt = 1'b0;
            if (q_cmd.read_word != lfsr_adv) begin
              fail_nxt  = rd_addr;
              phase_nxt = PH_FAILED;
            end else begin
              index_nxt = index_inc;
              if (last_word) begin
                phase_nxt = PH_PASSED;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res_nxt = '0;
    if (q_cmd.kind == KIND_READY) begin
      if (phase_r == PH_FILL) begin
        res_nxt.access_valid   = 1'b1;
        res_nxt.access_write   = 1'b1;
        res_nxt.access_address = wr_addr;
        res_nxt.write_word     = lfsr_adv;
      end else if (phase_r == PH_VERIFY && !await_r) begin
        res_nxt.access_valid   = 1'b1;
        res_nxt.access_address = rd_addr;
      end
    end
    case (phase_nxt)
      PH_FILL, PH_VERIFY: res_nxt.status = ST_RUNNING;
      PH_PASSED:          res_nxt.status = ST_PASSED;
      PH_FAILED:          res_nxt.status = ST_FAILED;
      default:            res_nxt.status = ST_IDLE;
    endcase
    if (phase_nxt == PH_FAILED) begin
      res_nxt.fail_address = fail_nxt;
    end
    out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      index_r     <= '0;
      lfsr_r      <= LFSR_SEED;
      await_r     <= 1'b0;
      fail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      index_r     <= index_nxt;
      lfsr_r      <= lfsr_nxt;
      await_r     <= await_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> src/lfsr_memory_pattern_test.sv
// Memory pattern self-test sequencer. Each input request (start, memory ready, read data)
// yields exactly one result carrying an optional access request and the test status.
// The block takes one request per clock unless the queue is full or the result stalls;
// the rate is set by the sequencer step (24-bit word index increment and compare, 16-bit
// lfsr advance and compare). Requests pass a four-entry queue and the result register.
// Configuration writes are registered before the sequencer uses them.
// top level: config registers, front queue, back sequencer, stream packing
// depends on lmpt_pkg, lmpt_front, lmpt_back
module lfsr_memory_pattern_test #(
  parameter int ADDR_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // read_word
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // access_valid, access_write, access_address, write_word, status, fail_address, zero pad
  output logic [lmpt_pkg::OUT_BITS-1:0] out_tdata
);
  import lmpt_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WRITE_BASE: cfg_nxt.write_base = cfg_data;
        CFG_READ_BASE:  cfg_nxt.read_base  = cfg_data;
        CFG_WORD_COUNT: cfg_nxt.word_count = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lmpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd)
  );

  lmpt_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {(OUT_BITS - $bits(res_t))'(0), res};

endmodule

>>> src/lmpt_checker.sv
// port-level checks on the result stream of the pattern test
// depends on lmpt_pkg and lfsr_memory_pattern_test_defines.svh; bound to lfsr_memory_pattern_test
`include "lfsr_memory_pattern_test_defines.svh"

module lmpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  import lmpt_pkg::*;

  // stalled result holds
  `LMPT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // no access request means zero write flag, access address and write word
  `LMPT_ASSERT_NOW(a_no_access_zero, out_tvalid && !out_tdata[0], out_tdata[41:1] == 41'd0)
  // fail address only shown when failed
  `LMPT_ASSERT_NOW(a_fail_addr, out_tvalid && out_tdata[43:42] != ST_FAILED,
                   out_tdata[71:44] == 28'd0)
  // writes only while running
  `LMPT_ASSERT_NOW(a_write_running, out_tvalid && out_tdata[1],
                   out_tdata[0] && out_tdata[43:42] == ST_RUNNING)

endmodule

bind lfsr_memory_pattern_test lmpt_checker u_lmpt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
